FILE: hdl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Used by bba_ctrl, bba_datapath and bitmap_block_allocator_top; no dependencies.
package bba_pkg;

  localparam int unsigned CNT_W  = 13;  // free count and configuration width
  localparam int unsigned BLK_W  = 12;  // block number width on the ports
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned WORD_W = 64;  // map bits held per memory word
  localparam int unsigned BIT_W  = 6;   // bit index within a map word

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FORMAT,
    S_SCAN,
    S_HIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // latch the incoming transaction
    logic sweep_wr;   // write the map word at the sweep address, advance
    logic clear;      // sweep writes zeros instead of the format pattern
    logic scan_rd;    // read the next map word of the scan
    logic hit_cap;    // capture the first non-empty word found
    logic hit_wr;     // take its lowest free block
    logic free_rd;    // read the word holding the block to release
    logic free_wr;    // set the block free unless it already is
    logic scan_miss;  // no free block anywhere
    logic out_load;   // move the result into the output register
  } bba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    op_e  in_op;
    logic in_oor;      // block to release lies at or above the total
    logic sweep_last;  // sweep is at the last map word
    logic scan_hit;
    logic scan_end;    // last word read back empty
    logic out_free;    // output register can take a result
  } bba_stat_t;

endpackage

FILE: hdl/bba_ctrl.sv
// Controller state machine of the bitmap block allocator.
// Sequences clearing, format, allocate scan and free; depends on bba_pkg.
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_pkg::bba_stat_t stat_i,
  output bba_pkg::bba_cmd_t  cmd_o,
  output logic              in_ready_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_wr = 1'b1;
        cmd_o.clear    = 1'b1;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.in_valid) begin
          cmd_o.accept = 1'b1;
          unique case (stat_i.in_op)
            OP_FORMAT: state_d = S_FORMAT;
            OP_ALLOC:  state_d = S_SCAN;
            OP_FREE:   state_d = stat_i.in_oor ? S_RESP : S_FREE_RD;
            OP_NOP:    state_d = S_RESP;
            default:   state_d = S_RESP;
          endcase
        end
      end
      S_FORMAT: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) state_d = S_RESP;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_hit) begin
          cmd_o.hit_cap = 1'b1;
          state_d       = S_HIT;
        end else if (stat_i.scan_end) begin
          cmd_o.scan_miss = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_HIT: begin
        cmd_o.hit_wr = 1'b1;
        state_d      = S_RESP;
      end
      S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd_o.free_wr = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/bba_datapath.sv
// Datapath of the bitmap block allocator: configuration, free map memory,
// sweep and scan addressing, free count and output register. Depends on bba_pkg.
module bba_datapath #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [bba_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic [bba_pkg::OP_W-1:0]    in_op_i,
  input  logic [bba_pkg::BLK_W-1:0]   in_blk_i,
  input  bba_pkg::bba_cmd_t           cmd_i,
  output bba_pkg::bba_stat_t          stat_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [bba_pkg::BLK_W-1:0]   out_granted_o,
  output logic [bba_pkg::CNT_W-1:0]   out_count_o,
  output logic [bba_pkg::STAT_W-1:0]  out_status_o
);
  import bba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SA_W      = WA_W + 1;
  localparam int unsigned CW        = (WA_W + 7 > 14) ? WA_W + 7 : 14;
  localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] MAX_SAT =
    CNT_W'((MAX_BLOCKS > CNT_MAX) ? CNT_MAX : MAX_BLOCKS);
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);
  localparam logic [SA_W-1:0] END_ADDR  = SA_W'(MAP_WORDS);

  // Configuration
  logic [CNT_W-1:0] total_q, reserved_q;
  logic [CNT_W-1:0] eff_total, eff_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= CNT_W'(4096);
      reserved_q <= CNT_W'(13);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 1'b0) begin
        total_q <= cfg_data_i;
      end else begin
        reserved_q <= cfg_data_i;
      end
    end
  end

  assign eff_total = (total_q > MAX_SAT) ? MAX_SAT : total_q;
  assign eff_res   = (reserved_q > eff_total) ? eff_total : reserved_q;

  // Transaction registers
  logic [BLK_W-1:0]  blk_q;
  logic [CNT_W-1:0]  count_q;
  logic [BLK_W-1:0]  granted_q;
  status_e           status_q;
  logic              in_oor;

  assign in_oor = ({1'b0, in_blk_i} >= eff_total);

  // Free map memory
  logic [WORD_W-1:0] map_mem [MAP_WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              we, re;
  logic [WA_W-1:0]   waddr, raddr, blk_word;
  logic [WORD_W-1:0] wdata;

  logic [SA_W-1:0]   addr_q;
  logic              addr_in_map;
  logic              rd_vld_q;
  logic [WA_W-1:0]   rd_tag_q;
  logic [WA_W-1:0]   hit_addr_q;
  logic [WORD_W-1:0] hit_word_q;
  logic [BIT_W-1:0]  hit_pos;
  logic              blk_is_free;
  logic [WORD_W-1:0] fmt_word;

  assign blk_word    = WA_W'(blk_q[BLK_W-1:BIT_W]);
  assign addr_in_map = (addr_q < END_ADDR);
  assign blk_is_free = rdata_q[blk_q[BIT_W-1:0]];

  // Format pattern of the word at the sweep address: free in [res, total)
  always_comb begin
    logic [CW-1:0]     base, res_c, tot_c, dlo, dhi;
    logic [WORD_W-1:0] lo_m, hi_m;
    base  = CW'({addr_q[WA_W-1:0], {BIT_W{1'b0}}});
    res_c = CW'(eff_res);
    tot_c = CW'(eff_total);
    dlo   = res_c - base;
    dhi   = tot_c - base;
    if (res_c <= base) begin
      lo_m = '1;
    end else if (res_c >= base + CW'(WORD_W)) begin
      lo_m = '0;
    end else begin
      lo_m = {WORD_W{1'b1}} << dlo[BIT_W-1:0];
    end
    if (tot_c >= base + CW'(WORD_W)) begin
      hi_m = '1;
    end else if (tot_c <= base) begin
      hi_m = '0;
    end else begin
      hi_m = ~({WORD_W{1'b1}} << dhi[BIT_W-1:0]);
    end
    fmt_word = lo_m & hi_m;
  end

  // Lowest set bit of the captured word
  always_comb begin
    hit_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_word_q[i]) hit_pos = BIT_W'(i);
    end
  end

  always_comb begin
    we    = cmd_i.sweep_wr | cmd_i.hit_wr | (cmd_i.free_wr & ~blk_is_free);
    waddr = blk_word;
    wdata = rdata_q | (WORD_W'(1) << blk_q[BIT_W-1:0]);
    if (cmd_i.sweep_wr) begin
      waddr = addr_q[WA_W-1:0];
      wdata = cmd_i.clear ? '0 : fmt_word;
    end else if (cmd_i.hit_wr) begin
      waddr = hit_addr_q;
      wdata = hit_word_q & (hit_word_q - WORD_W'(1));
    end
    re    = (cmd_i.scan_rd & addr_in_map) | cmd_i.free_rd;
    raddr = cmd_i.free_rd ? blk_word : addr_q[WA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) map_mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (re) rdata_q <= map_mem[raddr];
  end

  // Sweep and scan address, read tagging
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd & addr_in_map;
      if (cmd_i.accept) begin
        addr_q <= '0;
      end else if (cmd_i.sweep_wr || (cmd_i.scan_rd && addr_in_map)) begin
        addr_q <= addr_q + SA_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= addr_q[WA_W-1:0];
    if (cmd_i.hit_cap) begin
      hit_addr_q <= rd_tag_q;
      hit_word_q <= rdata_q;
    end
  end

  // Result and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept && (op_e'(in_op_i) == OP_FORMAT)) begin
      count_q <= eff_total - eff_res;
    end else if (cmd_i.hit_wr && (count_q != '0)) begin
      count_q <= count_q - CNT_W'(1);
    end else if (cmd_i.free_wr && !blk_is_free) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blk_q     <= in_blk_i;
      granted_q <= '0;
      status_q  <= ((op_e'(in_op_i) == OP_FREE) && in_oor) ? ST_OUT_OF_RANGE : ST_OK;
    end else if (cmd_i.scan_miss) begin
      status_q <= ST_NO_FREE;
    end else if (cmd_i.hit_wr) begin
      granted_q <= BLK_W'({hit_addr_q, hit_pos});
    end else if (cmd_i.free_wr && blk_is_free) begin
      status_q <= ST_ALREADY_FREE;
    end
  end

  // Output register
  logic              out_valid_q;
  logic [BLK_W-1:0]  out_granted_q;
  logic [CNT_W-1:0]  out_count_q;
  status_e           out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_granted_q <= granted_q;
      out_count_q   <= count_q;
      out_status_q  <= status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_granted_o = out_granted_q;
  assign out_count_o   = out_count_q;
  assign out_status_o  = out_status_q;

  always_comb begin
    stat_o            = '0;
    stat_o.in_valid   = in_valid_i;
    stat_o.in_op      = op_e'(in_op_i);
    stat_o.in_oor     = in_oor;
    stat_o.sweep_last = (addr_q[WA_W-1:0] == LAST_WORD);
    stat_o.scan_hit   = rd_vld_q && (rdata_q != '0);
    stat_o.scan_end   = rd_vld_q && (rdata_q == '0) && (rd_tag_q == LAST_WORD);
    stat_o.out_free   = ~out_valid_q | out_ready_i;
  end

endmodule

FILE: hdl/bitmap_block_allocator_top.sv
// First-fit bitmap block allocator with one free bit per block held in a
// memory of 64-bit words. Every transaction returns one result. Format writes
// one map word a cycle; allocate reads one map word a cycle from word zero
// until it meets a free block or the end of the map. After reset all
// MAP_WORDS map words (64 at the default size) are cleared before the first
// transaction is taken.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
module bitmap_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes: index 0 total_blocks, 1 reserved_blocks
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [0:0]                         cfg_index_i,
  input  logic [bba_pkg::CNT_W-1:0]          cfg_data_i,
  // Request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [11:0] block_number
  input  logic [bba_pkg::OP_W-1:0]           s_axis_tuser,   // [1:0] opcode
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [11:0] granted_block,
                                                             // [24:12] free_blocks
  output logic [bba_pkg::STAT_W-1:0]         m_axis_tuser    // [1:0] status
);
  import bba_pkg::*;

  bba_cmd_t         cmd;
  bba_stat_t        stat;
  logic [BLK_W-1:0] granted;
  logic [CNT_W-1:0] count;

  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_op_i       (s_axis_tuser),
    .in_blk_i      (s_axis_tdata[BLK_W-1:0]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_granted_o (granted),
    .out_count_o   (count),
    .out_status_o  (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'({count, granted});

endmodule
